// ===== hdl/gltp_pkg.sv =====
// ----------------------------------------------------------------------------
// gltp_pkg
// Types, character codes and the symbol decode shared by the gate list parser.
// ----------------------------------------------------------------------------
package gltp_pkg;

  localparam int unsigned RADIX      = 83;
  localparam int unsigned GATE_WIRES = 3;
  localparam int unsigned OUT_BITS   = 16;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_TILDE = 8'h7e;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_COUNT = 3'd1,
    ERR_CHAR  = 3'd2,
    ERR_OPEN  = 3'd3,
    ERR_WIDE  = 3'd4
  } err_t;

  typedef struct packed {
    logic       ok;
    logic [6:0] digit;
  } sym_t;

  // map one byte of the 83-symbol alphabet to its digit
  function automatic sym_t symbol_value(input logic [7:0] code);
    sym_t s;
    s.ok    = 1'b1;
    s.digit = 7'd0;
    case (code) inside
      ["0":"9"]: s.digit = 7'(code - 8'h30);
      ["a":"z"]: s.digit = 7'(code - 8'h61 + 8'd10);
      ["A":"Z"]: s.digit = 7'(code - 8'h41 + 8'd36);
      "!":       s.digit = 7'd62;
      "@":       s.digit = 7'd63;
      "#":       s.digit = 7'd64;
      "$":       s.digit = 7'd65;
      "%":       s.digit = 7'd66;
      "^":       s.digit = 7'd67;
      "&":       s.digit = 7'd68;
      "*":       s.digit = 7'd69;
      "(":       s.digit = 7'd70;
      ")":       s.digit = 7'd71;
      "-":       s.digit = 7'd72;
      "_":       s.digit = 7'd73;
      "=":       s.digit = 7'd74;
      "+":       s.digit = 7'd75;
      "[":       s.digit = 7'd76;
      "]":       s.digit = 7'd77;
      "{":       s.digit = 7'd78;
      "}":       s.digit = 7'd79;
      "<":       s.digit = 7'd80;
      ">":       s.digit = 7'd81;
      "?":       s.digit = 7'd82;
      default:   s.ok    = 1'b0;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/gate_list_text_parser_top.sv =====
// ----------------------------------------------------------------------------
// gate_list_text_parser_top
// Character stream parser that emits three-wire gates with a sticky error.
// ----------------------------------------------------------------------------
// One text character is taken per cycle unless out_ready stalls a result, and
// each item yields exactly one result. An input register feeds a single
// decode / multiply-add step that updates the parser state and loads the
// result register; while a result waits on out_ready the input register can
// still take one more item, and in_ready drops only once both registers are
// full, so the sustained rate is one item per cycle while out_ready is high.
// Wire numbers are held WIRE_BITS wide and presented on 16-bit ports; tilde
// prefixes are counted in TILDE_BITS bits.
module gate_list_text_parser_top #(
  parameter int unsigned WIRE_BITS  = 16,
  parameter int unsigned TILDE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        gate_valid,
  output logic [15:0] wire_a,
  output logic [15:0] wire_b,
  output logic [15:0] wire_c,
  output logic [2:0]  error_code
);
  import gltp_pkg::*;

  localparam int unsigned VAL_BITS = TILDE_BITS + 8;
  localparam int unsigned CMP_BITS = ((VAL_BITS > WIRE_BITS) ? VAL_BITS : WIRE_BITS) + 1;

  // input register
  logic       in_full;
  logic [7:0] char_q;
  logic       eoi_q;

  // parser state
  logic                  in_comment, in_comment_next;
  logic                  at_bol, at_bol_next;
  logic [TILDE_BITS-1:0] tilde_count, tilde_count_next;
  logic [2:0]            number_count, number_count_next;
  logic [WIRE_BITS-1:0]  held_numbers [GATE_WIRES];
  err_t                  sticky_error, sticky_error_next;

  logic                  hold_we;
  logic [1:0]            hold_idx;
  logic [WIRE_BITS-1:0]  hold_val;

  logic                  res_gate;
  err_t                  res_err;

  sym_t                  sym;
  logic [VAL_BITS-1:0]   value;
  logic [CMP_BITS-1:0]   value_ext;
  logic                  too_wide;

  logic advance;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  assign sym       = symbol_value(char_q);
  assign value     = VAL_BITS'(sym.digit) + VAL_BITS'(tilde_count) * VAL_BITS'(RADIX);
  assign value_ext = CMP_BITS'(value);
  assign too_wide  = (value_ext >> WIRE_BITS) != '0;

  always_comb begin
    in_comment_next    = in_comment;
    at_bol_next        = at_bol;
    tilde_count_next   = tilde_count;
    number_count_next  = number_count;
    sticky_error_next  = sticky_error;
    hold_we            = 1'b0;
    hold_idx           = number_count[1:0];
    hold_val           = WIRE_BITS'(value);
    res_gate           = 1'b0;
    res_err            = sticky_error;
    if (eoi_q) begin
      if (sticky_error == ERR_NONE && number_count != 3'd0) begin
        res_err = ERR_OPEN;
      end
      in_comment_next    = 1'b0;
      at_bol_next        = 1'b1;
      tilde_count_next   = '0;
      number_count_next  = 3'd0;
      sticky_error_next  = ERR_NONE;
    end else begin
      if (sticky_error == ERR_NONE) begin
        if (in_comment) begin
          if (char_q == CH_LF || char_q == CH_CR) begin
            in_comment_next = 1'b0;
            at_bol_next     = 1'b1;
          end
        end else if (at_bol && char_q == CH_HASH) begin
          in_comment_next = 1'b1;
        end else if (char_q == CH_SEMI) begin
          if (number_count != 3'd0) begin
            if (number_count != 3'(GATE_WIRES)) begin
              sticky_error_next = ERR_COUNT;
            end else begin
              res_gate = 1'b1;
            end
            number_count_next = 3'd0;
          end
          tilde_count_next = '0;
        end else if (char_q == CH_TILDE) begin
          if (&tilde_count) begin
            sticky_error_next = ERR_WIDE;
          end else begin
            tilde_count_next = tilde_count + 1'b1;
          end
          at_bol_next = 1'b0;
        end else if (char_q == CH_LF || char_q == CH_CR) begin
          at_bol_next = 1'b1;
        end else if (char_q == CH_TAB || char_q == CH_SPACE) begin
          // blank, skipped
        end else if (!sym.ok) begin
          sticky_error_next = ERR_CHAR;
        end else begin
          if (too_wide) begin
            sticky_error_next = ERR_WIDE;
          end else begin
            hold_we = number_count < 3'(GATE_WIRES);
            // count saturates one past a full gate
            if (number_count <= 3'(GATE_WIRES)) begin
              number_count_next = number_count + 3'd1;
            end
          end
          tilde_count_next = '0;
          at_bol_next      = 1'b0;
        end
      end
      res_err = sticky_error_next;
      if (sticky_error_next != ERR_NONE) begin
        res_gate = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_q <= char_code;
      eoi_q  <= end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_comment    <= 1'b0;
      at_bol        <= 1'b1;
      tilde_count   <= '0;
      number_count  <= 3'd0;
      sticky_error  <= ERR_NONE;
    end else if (advance) begin
      in_comment    <= in_comment_next;
      at_bol        <= at_bol_next;
      tilde_count   <= tilde_count_next;
      number_count  <= number_count_next;
      sticky_error  <= sticky_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_we) begin
      held_numbers[hold_idx] <= hold_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gate_valid <= res_gate;
      error_code <= res_err;
      if (res_gate) begin
        wire_a <= OUT_BITS'(held_numbers[0]);
        wire_b <= OUT_BITS'(held_numbers[1]);
        wire_c <= OUT_BITS'(held_numbers[2]);
      end else begin
        wire_a <= '0;
        wire_b <= '0;
        wire_c <= '0;
      end
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the gate list text parser: streams circuit text one character
// per item, predicts every result from a model of the parser state and checks
// each result field by field, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import gltp_pkg::*;

  localparam int unsigned WIRE_W         = 16;
  localparam int unsigned TILDE_W        = 10;
  localparam int unsigned TILDE_MAX      = (1 << TILDE_W) - 1;
  localparam int          RANDOM_ITEMS   = 1500;
  localparam int          HOLDOFF_CYCLES = 400;
  localparam int          IDLE_LIMIT     = 3000;
  localparam int          TAIL_CYCLES    = 10;

  typedef struct packed {
    logic        gate_valid;
    logic [15:0] wire_a;
    logic [15:0] wire_b;
    logic [15:0] wire_c;
    err_t        err;
  } gate_res_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  char_code;
  logic        end_of_input;
  logic        out_valid;
  logic        out_ready;
  logic        gate_valid;
  logic [15:0] wire_a;
  logic [15:0] wire_b;
  logic [15:0] wire_c;
  logic [2:0]  error_code;

  string symbols =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ!@#$%^&*()-_=+[]{}<>?";

  // parser state as predicted
  logic              in_cmt;
  logic              bol;
  int unsigned       tilde_run;
  int unsigned       num_count;
  logic [WIRE_W-1:0] held_nums [3];
  err_t              text_err;

  gate_res_t pending_gates[$];
  int        mismatches;
  int        items_sent;
  int        burst_left;
  bit        steady;
  int        holdoff_asked;
  int        idle_cycles;

  gate_list_text_parser_top #(
    .WIRE_BITS (WIRE_W),
    .TILDE_BITS(TILDE_W)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_code   (char_code),
    .end_of_input(end_of_input),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .gate_valid  (gate_valid),
    .wire_a      (wire_a),
    .wire_b      (wire_b),
    .wire_c      (wire_c),
    .error_code  (error_code)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int digit_of(input logic [7:0] ch);
    for (int i = 0; i < RADIX; i++) begin
      if (symbols[i] == ch) return i;
    end
    return -1;
  endfunction

  function automatic void parser_clear();
    in_cmt     = 1'b0;
    bol        = 1'b1;
    tilde_run  = 0;
    num_count  = 0;
    text_err   = ERR_NONE;
  endfunction

  // advance the parser by one character and return the result it gives
  function automatic gate_res_t parse_step(input logic [7:0] ch, input logic eoi);
    gate_res_t         r;
    int                d;
    longint unsigned   v;
    r = '0;
    if (eoi) begin
      r.err = (text_err == ERR_NONE && num_count != 0) ? ERR_OPEN : text_err;
      parser_clear();
      return r;
    end
    if (text_err == ERR_NONE) begin
      if (in_cmt) begin
        if (ch == CH_LF || ch == CH_CR) begin
          in_cmt = 1'b0;
          bol    = 1'b1;
        end
      end else if (bol && ch == CH_HASH) begin
        in_cmt = 1'b1;
      end else if (ch == CH_SEMI) begin
        if (num_count != 0) begin
          if (num_count != GATE_WIRES) begin
            text_err = ERR_COUNT;
          end else begin
            r.gate_valid = 1'b1;
            r.wire_a     = held_nums[0][15:0];
            r.wire_b     = held_nums[1][15:0];
            r.wire_c     = held_nums[2][15:0];
          end
          num_count = 0;
        end
        tilde_run = 0;
      end else if (ch == CH_TILDE) begin
        if (tilde_run >= TILDE_MAX) text_err = ERR_WIDE;
        else tilde_run++;
        bol = 1'b0;
      end else if (ch == CH_LF || ch == CH_CR) begin
        bol = 1'b1;
      end else if (ch != CH_TAB && ch != CH_SPACE) begin
        d = digit_of(ch);
        if (d < 0) begin
          text_err = ERR_CHAR;
        end else begin
          v = longint'(d) + longint'(RADIX) * longint'(tilde_run);
          if ((v >> WIRE_W) != 0) begin
            text_err = ERR_WIDE;
          end else begin
            if (num_count < GATE_WIRES) held_nums[num_count] = v[WIRE_W-1:0];
            if (num_count <= GATE_WIRES) num_count++;
          end
          tilde_run = 0;
          bol       = 1'b0;
        end
      end
    end
    if (text_err != ERR_NONE) begin
      r.gate_valid = 1'b0;
      r.wire_a     = '0;
      r.wire_b     = '0;
      r.wire_c     = '0;
    end
    r.err = text_err;
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(input logic [7:0] ch, input logic eoi);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid     <= 1'b1;
    char_code    <= ch;
    end_of_input <= eoi;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    pending_gates.insert(pending_gates.size(), parse_step(ch, eoi));
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_eoi();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_number(input int tildes, input int digit);
    repeat (tildes) send_item(CH_TILDE, 1'b0);
    send_item(symbols[digit], 1'b0);
  endtask

  // valid is already low when nothing is pending
  task automatic wait_drained();
    if (pending_gates.size() != 0) begin
      in_valid <= 1'b0;
      while (pending_gates.size() != 0) @(posedge clk);
    end
  endtask

  task automatic send_random_number();
    int r;
    int tildes;
    r = $urandom_range(0, 99);
    if (r < 60) tildes = 0;
    else if (r < 90) tildes = $urandom_range(1, 3);
    else if (r < 98) tildes = $urandom_range(4, 40);
    else tildes = $urandom_range(41, 120);
    send_number(tildes, $urandom_range(0, RADIX - 1));
  endtask

  // blank, line end, and now and then a comment line
  task automatic send_blank();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: send_item(CH_SPACE, 1'b0);
      1: send_item(CH_TAB, 1'b0);
      2: send_item(CH_CR, 1'b0);
      default: send_item(CH_LF, 1'b0);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      send_item(CH_HASH, 1'b0);
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_LF || b == CH_CR) b = CH_SEMI;
        send_item(b, 1'b0);
      end
      send_item($urandom_range(0, 1) ? CH_LF : CH_CR, 1'b0);
    end
  endtask

  task automatic send_random_gate();
    int r;
    int nums;
    r = $urandom_range(0, 19);
    nums = (r < 16) ? 3 : (r == 16) ? 1 : (r == 17) ? 2 : (r == 18) ? 4 : 0;
    for (int i = 0; i < nums; i++) begin
      if ($urandom_range(0, 3) == 0) send_blank();
      if ($urandom_range(0, 49) == 0) send_item(8'($urandom_range(0, 255)), 1'b0);
      send_random_number();
    end
    if ($urandom_range(0, 3) == 0) send_blank();
    if ($urandom_range(0, 29) != 0) send_item(CH_SEMI, 1'b0);
  endtask

  task automatic test_gates();
    send_text("#x;~\n0Z\t?;a#b;;\r#q\r");
    send_eoi();
    wait_drained();
  endtask

  task automatic test_errors();
    send_text("ab;c;");
    send_eoi();
    send_item(8'h00, 1'b0);
    send_eoi();
    send_item(8'hff, 1'b0);
    send_eoi();
    send_text("ab");
    send_eoi();
    send_text("abcd;");
    send_eoi();
    wait_drained();
  endtask

  // largest wire value, first value too wide, tilde counter overflow
  task automatic test_wide_values();
    send_number(789, 48);
    send_text("00;");
    send_number(789, 49);
    send_eoi();
    repeat (TILDE_MAX + 1) send_item(CH_TILDE, 1'b0);
    send_eoi();
    wait_drained();
  endtask

  task automatic test_backpressure();
    holdoff_asked++;
    steady = 1'b1;
    repeat (12) send_random_gate();
    steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_texts();
    int stop_at;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 8)) send_random_gate();
      if ($urandom_range(0, 9) != 0) send_eoi();
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    send_eoi();
    wait_drained();
  endtask

  task automatic log_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic check_result();
    gate_res_t e;
    if (pending_gates.size() == 0) begin
      log_mismatch($sformatf("result with no item pending: gate %0b %0d %0d %0d err %0d",
                             gate_valid, wire_a, wire_b, wire_c, error_code));
      return;
    end
    e = pending_gates.pop_front();
    if (gate_valid !== e.gate_valid || wire_a !== e.wire_a || wire_b !== e.wire_b ||
        wire_c !== e.wire_c || error_code !== e.err) begin
      log_mismatch($sformatf("expected gate %0b %0d %0d %0d err %0d, got %0b %0d %0d %0d err %0d",
                             e.gate_valid, e.wire_a, e.wire_b, e.wire_c, e.err,
                             gate_valid, wire_a, wire_b, wire_c, error_code));
    end
  endtask

  // outputs and out_ready only move at rising edges, so the falling edge sees
  // exactly what the next rising edge will take
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
  end

  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : receiver
    int  phase_left;
    int  holdoff_left;
    int  holdoffs_done;
    int  r;
    bit  rdy;
    phase_left    = 0;
    holdoff_left  = 0;
    holdoffs_done = 0;
    rdy           = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoffs_done != holdoff_asked) begin
        holdoffs_done = holdoff_asked;
        holdoff_left  = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          r = $urandom_range(0, 9);
          if (r < 5) begin
            rdy        = 1'b1;
            phase_left = $urandom_range(1, 30);
          end else if (r < 9) begin
            rdy        = 1'b0;
            phase_left = $urandom_range(1, 5);
          end else begin
            rdy        = 1'b1;
            phase_left = $urandom_range(100, 200);
          end
        end
        phase_left--;
        out_ready <= rdy;
      end
    end
  end

  initial begin
    mismatches    = 0;
    items_sent    = 0;
    burst_left    = 0;
    steady        = 1'b0;
    holdoff_asked = 0;
    idle_cycles   = 0;
    parser_clear();
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    char_code    <= 8'h00;
    end_of_input <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_gates();
    test_errors();
    test_wide_values();
    test_backpressure();
    test_random_texts();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/gltp_pkg.sv
hdl/gate_list_text_parser_top.sv
test/tb.sv
